[design/assert_macros.svh]
// Assertion macros shared by the lookup block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[design/ipsl_pkg.sv]
// Types, codes and helpers of the IPv4 prefix set lookup.
// Depends on nothing; used by all modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package ipsl_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned COUNT_W = 7;
    localparam logic [LEN_W-1:0] FULL_LEN = 6'd32;
    localparam logic [ADDR_W-1:0] ADDR_MASK = 32'hffff_ffff;

    typedef enum logic [1:0] {
        OP_WRITE_NEG = 2'd0,
        OP_WRITE_POS = 2'd1,
        OP_QUERY     = 2'd2,
        OP_RESERVED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_MISS    = 2'd1,
        ST_WRITTEN = 2'd2
    } status_t;

    localparam logic [1:0] CFG_NEG_COUNT = 2'd0;
    localparam logic [1:0] CFG_POS_COUNT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef struct packed {
        logic write_item;
        logic load_query;
        logic issue;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic last_issue;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= FULL_LEN)
            m = ADDR_MASK;
        else
            m = ~(ADDR_MASK >> len);
        return m;
    endfunction

endpackage

`default_nettype wire

[design/ipsl_ctrl.sv]
// Sequencer of the prefix lookup: accepts words, steps the table scan.
// Depends on ipsl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ipsl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          operation,
    input  wire ipsl_pkg::dp_status_t dp_status,
    output logic                     busy,
    output ipsl_pkg::ctl_cmd_t       cmd
);
    import ipsl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (operation == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                        cmd.write_item = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (dp_status.last_issue)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_FINISH;
            S_FINISH:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `ASSERT_PROP(a_query_scans, clk, rst_n,
        (accept && operation == OP_QUERY) |=> (state_reg == S_SCAN))
    `ASSERT_PROP(a_write_stays_idle, clk, rst_n,
        (accept && operation != OP_QUERY) |=> (state_reg == S_IDLE))
    `ASSERT_PROP(a_drain_then_emit, clk, rst_n,
        (state_reg == S_DRAIN) |=> (cmd.emit && busy))
    `ASSERT_NEVER(a_emit_while_issue, clk, rst_n,
        cmd.emit && (cmd.issue || cmd.load_query || cmd.write_item))

endmodule

`default_nettype wire

[design/ipsl_datapath.sv]
// Tables, configuration registers, scan pipeline and result registers.
// Depends on ipsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipsl_datapath #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ipsl_pkg::ctl_cmd_t           cmd,
    output ipsl_pkg::dp_status_t              dp_status,
    input  wire logic [1:0]                   operation,
    input  wire logic [ipsl_pkg::SLOT_W-1:0]  slot,
    input  wire logic [ipsl_pkg::ADDR_W-1:0]  address,
    input  wire logic [ipsl_pkg::LEN_W-1:0]   prefix_len,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [ipsl_pkg::COUNT_W-1:0] cfg_data,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [ipsl_pkg::SLOT_W-1:0]       specific_index,
    output logic [ipsl_pkg::SLOT_W-1:0]       general_index
);
    import ipsl_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LIM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    entry_t neg_mem [TABLE_DEPTH];
    entry_t pos_mem [TABLE_DEPTH];

    logic [COUNT_W-1:0] neg_count_reg;
    logic [COUNT_W-1:0] pos_count_reg;

    logic [ADDR_W-1:0]  query_reg;
    logic [LIM_W-1:0]   scan_reg;
    entry_t             neg_q_reg;
    entry_t             pos_q_reg;
    logic               rd_valid_reg;
    logic               neg_ok_reg;
    logic               pos_ok_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic               excluded_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   spec_reg;
    logic [IDX_W-1:0]   gen_reg;
    logic [LEN_W-1:0]   spec_len_reg;
    logic [LEN_W-1:0]   gen_len_reg;

    logic               done_reg;
    logic [1:0]         status_reg;
    logic [SLOT_W-1:0]  spec_out_reg;
    logic [SLOT_W-1:0]  gen_out_reg;

    logic [LIM_W-1:0]   neg_used;
    logic [LIM_W-1:0]   pos_used;
    logic [LIM_W-1:0]   limit;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [LEN_W-1:0]   wr_len;
    entry_t             wr_entry;
    logic               slot_ok;
    logic               is_write;
    logic               neg_hit;
    logic               pos_hit;

    always_comb
    begin
        neg_used = (LIM_W'(neg_count_reg) > LIM_W'(TABLE_DEPTH))
                   ? LIM_W'(TABLE_DEPTH) : LIM_W'(neg_count_reg);
        pos_used = (LIM_W'(pos_count_reg) > LIM_W'(TABLE_DEPTH))
                   ? LIM_W'(TABLE_DEPTH) : LIM_W'(pos_count_reg);
        limit    = (neg_used > pos_used) ? neg_used : pos_used;
        dp_status.last_issue = ((LIM_W + 1)'(scan_reg) + (LIM_W + 1)'(1))
                               >= (LIM_W + 1)'(limit);
    end

    assign rd_addr  = scan_reg[IDX_W-1:0];
    assign wr_addr  = IDX_W'(slot);
    assign wr_len   = (prefix_len > FULL_LEN) ? FULL_LEN : prefix_len;
    assign wr_entry = '{addr: address & len_mask(wr_len), len: wr_len};
    assign slot_ok  = (32'(slot) < 32'(TABLE_DEPTH));
    assign is_write = (operation == OP_WRITE_NEG) || (operation == OP_WRITE_POS);

    assign neg_hit = rd_valid_reg && neg_ok_reg
                     && ((query_reg & len_mask(neg_q_reg.len)) == neg_q_reg.addr);
    assign pos_hit = rd_valid_reg && pos_ok_reg
                     && ((query_reg & len_mask(pos_q_reg.len)) == pos_q_reg.addr);

    // Table storage: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (cmd.write_item && slot_ok && operation == OP_WRITE_NEG)
            neg_mem[wr_addr] <= wr_entry;
        if (cmd.write_item && slot_ok && operation == OP_WRITE_POS)
            pos_mem[wr_addr] <= wr_entry;
        if (cmd.issue)
        begin
            neg_q_reg <= neg_mem[rd_addr];
            pos_q_reg <= pos_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_count_reg <= '0;
            pos_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NEG_COUNT)
                neg_count_reg <= cfg_data;
            else if (cfg_index == CFG_POS_COUNT)
                pos_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            excluded_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
            done_reg     <= cmd.write_item || cmd.emit;
            if (cmd.load_query)
            begin
                scan_reg     <= '0;
                excluded_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                    scan_reg <= scan_reg + LIM_W'(1);
                if (neg_hit)
                    excluded_reg <= 1'b1;
                if (pos_hit)
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
            query_reg <= address;
        if (cmd.issue)
        begin
            neg_ok_reg <= scan_reg < neg_used;
            pos_ok_reg <= scan_reg < pos_used;
            rd_idx_reg <= rd_addr;
        end
        if (pos_hit)
        begin
            if (!found_reg)
            begin
                spec_reg     <= rd_idx_reg;
                gen_reg      <= rd_idx_reg;
                spec_len_reg <= pos_q_reg.len;
                gen_len_reg  <= pos_q_reg.len;
            end
            else
            begin
                if (pos_q_reg.len > spec_len_reg)
                begin
                    spec_reg     <= rd_idx_reg;
                    spec_len_reg <= pos_q_reg.len;
                end
                if (pos_q_reg.len < gen_len_reg)
                begin
                    gen_reg     <= rd_idx_reg;
                    gen_len_reg <= pos_q_reg.len;
                end
            end
        end
        if (cmd.write_item)
        begin
            status_reg   <= (is_write && slot_ok) ? ST_WRITTEN : ST_MISS;
            spec_out_reg <= '0;
            gen_out_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            if (found_reg && !excluded_reg)
            begin
                status_reg   <= ST_FOUND;
                spec_out_reg <= SLOT_W'(spec_reg);
                gen_out_reg  <= SLOT_W'(gen_reg);
            end
            else
            begin
                status_reg   <= ST_MISS;
                spec_out_reg <= '0;
                gen_out_reg  <= '0;
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign specific_index = spec_out_reg;
    assign general_index  = gen_out_reg;

endmodule

`default_nettype wire

[design/ipv4_prefix_set_lookup.sv]
// Top level of the IPv4 prefix set lookup: sequencer plus datapath.
// Depends on ipsl_pkg, ipsl_ctrl and ipsl_datapath.
`timescale 1ns / 1ps
`default_nettype none

// A word is taken when start is high and busy is low. Table writes leave
// the block idle for a new word in the very next cycle. A query scans
// both tables in parallel, one registered memory read per cycle, over N =
// max(1, used negative count, used positive count) slots; busy stays high
// in the scan, drain and finish states, and finish registers the result.
// Every word gives one result, shown for exactly one cycle with done
// high; the receiver cannot stall, so take it then. Write counts through
// cfg_we only while the block is idle; the block does not enforce this.
// Tables hold no reset value; load every slot in use before querying.
module ipv4_prefix_set_lookup #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   operation,
    input  wire logic [ipsl_pkg::SLOT_W-1:0]  slot,
    input  wire logic [ipsl_pkg::ADDR_W-1:0]  address,
    input  wire logic [ipsl_pkg::LEN_W-1:0]   prefix_len,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [ipsl_pkg::COUNT_W-1:0] cfg_data,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [ipsl_pkg::SLOT_W-1:0]       specific_index,
    output logic [ipsl_pkg::SLOT_W-1:0]       general_index
);
    import ipsl_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t dp_status;

    ipsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .dp_status (dp_status),
        .busy      (busy),
        .cmd       (cmd)
    );

    ipsl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .operation      (operation),
        .slot           (slot),
        .address        (address),
        .prefix_len     (prefix_len),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .specific_index (specific_index),
        .general_index  (general_index)
    );

endmodule

`default_nettype wire
